/* hw/rtl/lkvt_pkg.sv */
// Shared types and constants for the linear key/value table.
package lkvt_pkg;

    // Default sizes of the table.
    localparam int CAPACITY    = 16;
    localparam int KEY_WIDTH   = 32;
    localparam int VALUE_WIDTH = 32;

    // Depth of the request queue between the front and the back end.
    localparam int QUEUE_DEPTH = 2;

    // Request mode codes as they arrive on the input stream.
    localparam logic [2:0] MODE_PUT       = 3'd0;
    localparam logic [2:0] MODE_GET       = 3'd1;
    localparam logic [2:0] MODE_REMOVE    = 3'd2;
    localparam logic [2:0] MODE_HAS_KEY   = 3'd3;
    localparam logic [2:0] MODE_HAS_VALUE = 3'd4;
    localparam int         MODE_WIDTH     = 3;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_GET,
        OP_REMOVE,
        OP_HAS_KEY,
        OP_HAS_VALUE,
        OP_NONE
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT
    } state_t;

    // Result fields of one finished request.
    typedef struct packed {
        logic found;
        logic table_full;
    } flags_t;

endpackage

/* hw/rtl/lkvt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lkvt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

/* hw/rtl/lkvt_front.sv */
// Front end: takes request beats, decodes the mode and queues the requests.
module lkvt_front #(
    parameter int KEY_WIDTH   = lkvt_pkg::KEY_WIDTH,
    parameter int VALUE_WIDTH = lkvt_pkg::VALUE_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [2:0]             in_mode,
    input  logic [KEY_WIDTH-1:0]   in_key,
    input  logic [VALUE_WIDTH-1:0] in_value,
    output logic                   cmd_valid,
    input  logic                   cmd_pop,
    output lkvt_pkg::op_t          cmd_op,
    output logic [KEY_WIDTH-1:0]   cmd_key,
    output logic [VALUE_WIDTH-1:0] cmd_value
);

    localparam int QD  = lkvt_pkg::QUEUE_DEPTH;
    localparam int PW  = (QD > 1) ? $clog2(QD) : 1;
    localparam int FW  = $clog2(QD + 1);

    lkvt_pkg::op_t          q_op_reg  [QD];
    logic [KEY_WIDTH-1:0]   q_key_reg [QD];
    logic [VALUE_WIDTH-1:0] q_val_reg [QD];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0] fill_reg, fill_next;
    lkvt_pkg::op_t dec_op;
    logic          push;
    logic          pop;

    always_comb
    begin
        unique case (in_mode)
            lkvt_pkg::MODE_PUT:       dec_op = lkvt_pkg::OP_PUT;
            lkvt_pkg::MODE_GET:       dec_op = lkvt_pkg::OP_GET;
            lkvt_pkg::MODE_REMOVE:    dec_op = lkvt_pkg::OP_REMOVE;
            lkvt_pkg::MODE_HAS_KEY:   dec_op = lkvt_pkg::OP_HAS_KEY;
            lkvt_pkg::MODE_HAS_VALUE: dec_op = lkvt_pkg::OP_HAS_VALUE;
            default:                  dec_op = lkvt_pkg::OP_NONE;
        endcase
    end

    assign in_ready  = (fill_reg != FW'(QD));
    assign cmd_valid = (fill_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = cmd_pop && cmd_valid;

    assign cmd_op    = q_op_reg[rd_ptr_reg];
    assign cmd_key   = q_key_reg[rd_ptr_reg];
    assign cmd_value = q_val_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QD - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QD - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + FW'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_op_reg[wr_ptr_reg]  <= dec_op;
            q_key_reg[wr_ptr_reg] <= in_key;
            q_val_reg[wr_ptr_reg] <= in_value;
        end
    end

endmodule

/* hw/rtl/lkvt_engine.sv */
// Back end: scans and updates the entry RAM for one request at a time.
module lkvt_engine #(
    parameter int CAPACITY    = lkvt_pkg::CAPACITY,
    parameter int KEY_WIDTH   = lkvt_pkg::KEY_WIDTH,
    parameter int VALUE_WIDTH = lkvt_pkg::VALUE_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_pop,
    input  lkvt_pkg::op_t                   cmd_op,
    input  logic [KEY_WIDTH-1:0]            cmd_key,
    input  logic [VALUE_WIDTH-1:0]          cmd_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output lkvt_pkg::flags_t                out_flags,
    output logic [VALUE_WIDTH-1:0]          out_value,
    output logic [$clog2(CAPACITY+1)-1:0]   out_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int DW = KEY_WIDTH + VALUE_WIDTH;

    lkvt_pkg::state_t       state_reg, state_next;
    lkvt_pkg::op_t          op_reg, op_next;
    logic [KEY_WIDTH-1:0]   key_reg, key_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          scan_idx_reg, scan_idx_next;
    logic [CW-1:0]          chk_idx_reg, chk_idx_next;
    logic                   chk_valid_reg, chk_valid_next;
    logic [CW-1:0]          sh_rd_reg, sh_rd_next;
    logic [AW-1:0]          wr_idx_reg, wr_idx_next;
    logic                   wr_valid_reg, wr_valid_next;
    logic                   out_valid_reg, out_valid_next;
    lkvt_pkg::flags_t       out_flags_reg;
    logic [VALUE_WIDTH-1:0] out_value_reg;
    logic [CW-1:0]          out_count_reg;

    logic                   load_out;
    lkvt_pkg::flags_t       res_flags;
    logic [VALUE_WIDTH-1:0] res_value;
    logic [CW-1:0]          res_count;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [DW-1:0]          ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [DW-1:0]          ram_rdata;
    logic [KEY_WIDTH-1:0]   rd_key;
    logic [VALUE_WIDTH-1:0] rd_val;
    logic                   slot_free;
    logic                   issue;
    logic                   hit;

    lkvt_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key    = ram_rdata[KEY_WIDTH-1:0];
    assign rd_val    = ram_rdata[KEY_WIDTH +: VALUE_WIDTH];
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        chk_idx_next   = chk_idx_reg;
        chk_valid_next = chk_valid_reg;
        sh_rd_next     = sh_rd_reg;
        wr_idx_next    = wr_idx_reg;
        wr_valid_next  = wr_valid_reg;
        cmd_pop        = 1'b0;
        load_out       = 1'b0;
        res_flags      = '0;
        res_value      = '0;
        res_count      = count_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[AW-1:0];
        ram_wdata      = {val_reg, key_reg};
        ram_raddr      = scan_idx_reg[AW-1:0];
        issue          = 1'b0;
        hit            = 1'b0;

        unique case (state_reg)
            lkvt_pkg::ST_IDLE:
            begin
                if (cmd_valid && slot_free)
                begin
                    cmd_pop        = 1'b1;
                    op_next        = cmd_op;
                    key_next       = cmd_key;
                    val_next       = cmd_value;
                    scan_idx_next  = '0;
                    chk_valid_next = 1'b0;
                    if (cmd_op == lkvt_pkg::OP_NONE)
                    begin
                        load_out = 1'b1;
                    end
                    else
                    begin
                        state_next = lkvt_pkg::ST_SCAN;
                    end
                end
            end

            lkvt_pkg::ST_SCAN:
            begin
                // Reads run one entry ahead of the compare.
                issue = (scan_idx_reg < count_reg);
                if (op_reg == lkvt_pkg::OP_HAS_VALUE)
                begin
                    hit = chk_valid_reg && (rd_val == val_reg);
                end
                else
                begin
                    hit = chk_valid_reg && (rd_key == key_reg);
                end

                if (hit)
                begin
                    load_out   = 1'b1;
                    state_next = lkvt_pkg::ST_IDLE;
                    case (op_reg) inside
                        lkvt_pkg::OP_GET:
                        begin
                            res_flags.found = 1'b1;
                            res_value       = rd_val;
                        end
                        lkvt_pkg::OP_HAS_KEY, lkvt_pkg::OP_HAS_VALUE:
                        begin
                            res_flags.found = 1'b1;
                        end
                        lkvt_pkg::OP_REMOVE:
                        begin
                            res_flags.found = 1'b1;
                            res_value       = rd_val;
                            res_count       = count_reg - CW'(1);
                            if ((chk_idx_reg + CW'(1)) < count_reg)
                            begin
                                sh_rd_next    = chk_idx_reg + CW'(1);
                                wr_valid_next = 1'b0;
                                state_next    = lkvt_pkg::ST_SHIFT;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        default:
                        begin
                            // A put of a key already present changes nothing.
                        end
                    endcase
                end
                else if (!chk_valid_reg && !issue)
                begin
                    load_out   = 1'b1;
                    state_next = lkvt_pkg::ST_IDLE;
                    if (op_reg == lkvt_pkg::OP_PUT)
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            res_flags.table_full = 1'b1;
                        end
                        else
                        begin
                            ram_we          = 1'b1;
                            count_next      = count_reg + CW'(1);
                            res_count       = count_reg + CW'(1);
                            res_flags.found = 1'b1;
                        end
                    end
                end
                else
                begin
                    chk_valid_next = issue;
                    chk_idx_next   = scan_idx_reg;
                    if (issue)
                    begin
                        scan_idx_next = scan_idx_reg + CW'(1);
                    end
                end
            end

            lkvt_pkg::ST_SHIFT:
            begin
                // Each entry after the removed one is read and written one slot lower.
                ram_raddr = sh_rd_reg[AW-1:0];
                ram_waddr = wr_idx_reg;
                ram_wdata = ram_rdata;
                ram_we    = wr_valid_reg;
                issue     = (sh_rd_reg < count_reg);
                if (issue)
                begin
                    sh_rd_next    = sh_rd_reg + CW'(1);
                    wr_idx_next   = AW'(sh_rd_reg - CW'(1));
                    wr_valid_next = 1'b1;
                end
                else
                begin
                    wr_valid_next = 1'b0;
                    count_next    = count_reg - CW'(1);
                    state_next    = lkvt_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lkvt_pkg::ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lkvt_pkg::ST_IDLE;
            count_reg     <= '0;
            chk_valid_reg <= 1'b0;
            wr_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_valid_reg <= chk_valid_next;
            wr_valid_reg  <= wr_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        scan_idx_reg <= scan_idx_next;
        chk_idx_reg  <= chk_idx_next;
        sh_rd_reg    <= sh_rd_next;
        wr_idx_reg   <= wr_idx_next;
        if (load_out)
        begin
            out_flags_reg <= res_flags;
            out_value_reg <= res_value;
            out_count_reg <= res_count;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_flags = out_flags_reg;
    assign out_value = out_value_reg;
    assign out_count = out_count_reg;

endmodule

/* hw/rtl/linear_key_value_table_top.sv */
// Top level of the linear key/value table.
//
// Requests enter as beats on the s_axis channel: a mode (put, get, remove,
// contains key, contains value), a key and a value. Every request yields
// exactly one result beat on the m_axis channel: found, the matched value,
// the full flag and the entry count after the operation.
// Entries sit packed in insertion order in one RAM with a single read and a
// single write port, and the back end walks them one per cycle. With N
// entries held, a request that finds no match has its result once all N
// entries are compared, and one that matches entry i has it once entry i
// is compared. A remove that matches entry i then moves the later entries
// down before the next request starts. An unused mode is answered straight
// from the idle state without a scan.
// A two-deep request queue keeps s_tready high while it has room, so new beats
// are taken while the back end works or a result waits. When the receiver
// holds m_tready low the result stays in its output register, the back end
// stops before the next request, and the queue fills and then drops s_tready.
// Reset empties the table and the queue at once; no clearing pass is run.
module linear_key_value_table_top #(
    parameter int CAPACITY    = lkvt_pkg::CAPACITY,
    parameter int KEY_WIDTH   = lkvt_pkg::KEY_WIDTH,
    parameter int VALUE_WIDTH = lkvt_pkg::VALUE_WIDTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // Fields from bit 0 up: mode, key, value, zero padding.
    input  logic [((lkvt_pkg::MODE_WIDTH + KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // Fields from bit 0 up: found, result_value, table_full, entry_count, zero padding.
    output logic [((2 + VALUE_WIDTH + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int MW    = lkvt_pkg::MODE_WIDTH;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int OUT_W = ((2 + VALUE_WIDTH + CW + 7) / 8) * 8;

    logic                   cmd_valid;
    logic                   cmd_pop;
    lkvt_pkg::op_t          cmd_op;
    logic [KEY_WIDTH-1:0]   cmd_key;
    logic [VALUE_WIDTH-1:0] cmd_value;
    lkvt_pkg::flags_t       res_flags;
    logic [VALUE_WIDTH-1:0] res_value;
    logic [CW-1:0]          res_count;

    lkvt_front #(
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tdata[MW-1:0]),
        .in_key    (s_tdata[MW +: KEY_WIDTH]),
        .in_value  (s_tdata[MW + KEY_WIDTH +: VALUE_WIDTH]),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd_op    (cmd_op),
        .cmd_key   (cmd_key),
        .cmd_value (cmd_value)
    );

    lkvt_engine #(
        .CAPACITY    (CAPACITY),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd_op    (cmd_op),
        .cmd_key   (cmd_key),
        .cmd_value (cmd_value),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_flags (res_flags),
        .out_value (res_value),
        .out_count (res_count)
    );

    assign m_tdata = OUT_W'({res_count, res_flags.table_full, res_value, res_flags.found});

endmodule

/* dv/linear_key_value_table_top_tb.sv */
// Self-checking testbench for the linear key/value table top level.
module linear_key_value_table_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP    = lkvt_pkg::CAPACITY;
    localparam int KW     = lkvt_pkg::KEY_WIDTH;
    localparam int VW     = lkvt_pkg::VALUE_WIDTH;
    localparam int CNT_W  = $clog2(CAP + 1);
    localparam int S_W    = ((lkvt_pkg::MODE_WIDTH + KW + VW + 7) / 8) * 8;
    localparam int M_W    = ((2 + VW + CNT_W + 7) / 8) * 8;
    localparam int STALL_LIMIT = 4000;
    localparam int KEY_POOL_SIZE = 24;
    localparam logic [2:0] MODE_UNUSED_LOW  = 3'd5;
    localparam logic [2:0] MODE_UNUSED_HIGH = 3'd7;

    typedef struct packed {
        logic            found;
        logic [VW-1:0]   value;
        logic            full;
        logic [CNT_W-1:0] count;
    } table_result_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;

    // Shadow copy of the table contents.
    logic [KW-1:0]  shadow_keys [CAP];
    logic [VW-1:0]  shadow_values [CAP];
    int             shadow_count;

    table_result_t  pending_results [$];
    logic [KW-1:0]  key_pool [KEY_POOL_SIZE];
    logic [VW-1:0]  value_pool [4];

    int error_count;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    linear_key_value_table_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int find_entry(input logic [KW-1:0] key);
        for (int i = 0; i < shadow_count; i++)
        begin
            if (shadow_keys[i] == key)
                return i;
        end
        return shadow_count;
    endfunction

    // Applies one request to the shadow table and returns the expected result beat.
    function automatic table_result_t apply_request(input logic [2:0] mode,
                                                    input logic [KW-1:0] key,
                                                    input logic [VW-1:0] value);
        table_result_t res;
        int idx;
        res = '0;
        idx = find_entry(key);
        case (mode)
            lkvt_pkg::MODE_PUT:
            begin
                if (idx == shadow_count)
                begin
                    if (shadow_count >= CAP)
                        res.full = 1'b1;
                    else
                    begin
                        shadow_keys[shadow_count] = key;
                        shadow_values[shadow_count] = value;
                        shadow_count++;
                        res.found = 1'b1;
                    end
                end
            end
            lkvt_pkg::MODE_GET:
            begin
                if (idx < shadow_count)
                begin
                    res.found = 1'b1;
                    res.value = shadow_values[idx];
                end
            end
            lkvt_pkg::MODE_REMOVE:
            begin
                if (idx < shadow_count)
                begin
                    res.found = 1'b1;
                    res.value = shadow_values[idx];
                    for (int j = idx; j + 1 < shadow_count; j++)
                    begin
                        shadow_keys[j] = shadow_keys[j + 1];
                        shadow_values[j] = shadow_values[j + 1];
                    end
                    shadow_count--;
                end
            end
            lkvt_pkg::MODE_HAS_KEY:
                res.found = (idx < shadow_count);
            lkvt_pkg::MODE_HAS_VALUE:
            begin
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (shadow_values[i] == value)
                        res.found = 1'b1;
                end
            end
            default:
                ;
        endcase
        res.count = CNT_W'(shadow_count);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    // Drives one request beat and records its expected result once accepted.
    task automatic send_request(input logic [2:0] mode, input logic [KW-1:0] key,
                                input logic [VW-1:0] value);
        logic [S_W-1:0] beat;
        beat = '0;
        beat[lkvt_pkg::MODE_WIDTH-1:0] = mode;
        beat[lkvt_pkg::MODE_WIDTH +: KW] = key;
        beat[lkvt_pkg::MODE_WIDTH + KW +: VW] = value;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= beat;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(apply_request(mode, key, value));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_result(input logic [M_W-1:0] beat);
        table_result_t want;
        table_result_t got;
        got.found = beat[0];
        got.value = beat[VW:1];
        got.full  = beat[VW + 1];
        got.count = beat[VW + 2 +: CNT_W];
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("result beat with nothing outstanding: %h", beat));
            return;
        end
        want = pending_results.pop_front();
        if (got.found !== want.found)
            report_mismatch($sformatf("found %b, want %b", got.found, want.found));
        if (got.value !== want.value)
            report_mismatch($sformatf("result_value %h, want %h", got.value, want.value));
        if (got.full !== want.full)
            report_mismatch($sformatf("table_full %b, want %b", got.full, want.full));
        if (got.count !== want.count)
            report_mismatch($sformatf("entry_count %0d, want %0d", got.count, want.count));
    endtask

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (rst_n && m_tvalid && m_tready)
            check_result(m_tdata);
    end

    // Ends the run if neither side moves a beat for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("linear_key_value_table_top_tb: errors");
            $finish;
        end
    end

    task automatic test_empty_table();
        send_request(lkvt_pkg::MODE_GET, '0, '0);
        send_request(lkvt_pkg::MODE_REMOVE, '1, '0);
        send_request(lkvt_pkg::MODE_HAS_KEY, '0, '0);
        send_request(lkvt_pkg::MODE_HAS_VALUE, '0, '0);
    endtask

    task automatic test_basic_ops();
        send_request(lkvt_pkg::MODE_PUT, '0, '0);
        send_request(lkvt_pkg::MODE_PUT, '1, '1);
        send_request(lkvt_pkg::MODE_PUT, '0, 32'h1234_5678);
        send_request(lkvt_pkg::MODE_GET, '0, '1);
        send_request(lkvt_pkg::MODE_GET, '1, '0);
        send_request(lkvt_pkg::MODE_HAS_VALUE, '0, '1);
        send_request(lkvt_pkg::MODE_HAS_VALUE, '1, 32'h1234_5678);
        send_request(lkvt_pkg::MODE_HAS_KEY, '1, '0);
        for (int m = MODE_UNUSED_LOW; m <= MODE_UNUSED_HIGH; m++)
            send_request(3'(m), '1, '1);
        send_request(lkvt_pkg::MODE_REMOVE, '0, '0);
        send_request(lkvt_pkg::MODE_GET, '0, '0);
    endtask

    task automatic test_fill_and_full();
        int n;
        n = 0;
        // Values repeat every third entry so that contains-value sees duplicates.
        while (shadow_count < CAP)
        begin
            send_request(lkvt_pkg::MODE_PUT, 32'hA500_0000 + KW'(n),
                         32'h5A5A_0000 + VW'(n % 3));
            n++;
        end
        send_request(lkvt_pkg::MODE_PUT, 32'h0BAD_0000, 32'h1);
        send_request(lkvt_pkg::MODE_PUT, 32'hA500_0000, 32'h2);
        send_request(lkvt_pkg::MODE_HAS_VALUE, '0, 32'h5A5A_0001);
    endtask

    task automatic test_remove_order();
        send_request(lkvt_pkg::MODE_REMOVE, shadow_keys[CAP / 2], '0);
        send_request(lkvt_pkg::MODE_GET, shadow_keys[CAP / 2], '0);
        send_request(lkvt_pkg::MODE_REMOVE, shadow_keys[shadow_count - 1], '0);
        send_request(lkvt_pkg::MODE_REMOVE, shadow_keys[0], '0);
        send_request(lkvt_pkg::MODE_GET, shadow_keys[shadow_count - 1], '0);
        send_request(lkvt_pkg::MODE_HAS_KEY, shadow_keys[0], '0);
    endtask

    task automatic test_random(input int items, input int put_pct);
        logic [2:0]    mode;
        logic [KW-1:0] key;
        logic [VW-1:0] value;
        int            r;
        for (int i = 0; i < KEY_POOL_SIZE; i++)
            key_pool[i] = $urandom();
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 0; i < 4; i++)
            value_pool[i] = $urandom();
        for (int n = 0; n < items; n++)
        begin
            r = $urandom_range(0, 99);
            if (r >= 95)
                mode = 3'($urandom_range(MODE_UNUSED_LOW, MODE_UNUSED_HIGH));
            else if (r < put_pct)
                mode = lkvt_pkg::MODE_PUT;
            else
                mode = 3'($urandom_range(lkvt_pkg::MODE_GET, lkvt_pkg::MODE_HAS_VALUE));
            if ($urandom_range(0, 9) < 8)
                key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
            else
                key = $urandom();
            if ($urandom_range(0, 3) == 0)
                value = value_pool[$urandom_range(0, 3)];
            else
                value = $urandom();
            // Aim contains-value at a stored value half of the time when the table holds entries.
            if (mode == lkvt_pkg::MODE_HAS_VALUE && shadow_count > 0
                && $urandom_range(0, 1) == 0)
                value = shadow_values[$urandom_range(0, shadow_count - 1)];
            send_request(mode, key, value);
        end
    endtask

    initial
    begin
        error_count = 0;
        shadow_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        quiet_cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_basic_ops();
        wait_drained();
        test_fill_and_full();
        test_remove_order();
        wait_drained();

        test_random(277, 35);
        wait_drained();
        send_idle_pct = 67;
        test_random(277, 20);
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 67;
        test_random(277, 40);
        wait_drained();
        send_idle_pct = 9;
        recv_stall_pct = 9;
        test_random(277, 25);
        wait_drained();

        repeat (2 * CAP + 10) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (error_count == 0)
            $display("linear_key_value_table_top_tb: clean");
        else
            $display("linear_key_value_table_top_tb: errors");
        $finish;
    end

endmodule
